// ===== rtl/bitmap_font_text_renderer_macros.svh =====
// assertion macros for the bitmap font text renderer checker
// no dependencies; included by the checker file only
`ifndef BITMAP_FONT_TEXT_RENDERER_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BFTR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap font text renderer assertion failed");

// next-cycle implication, disabled during reset
`define BFTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap font text renderer assertion failed");

`endif

// ===== rtl/bftr_pkg.sv =====
// shared constants, types and helpers of the bitmap font text renderer
// no dependencies; used by every rtl module of the block
package bftr_pkg;

    localparam int GLYPH_STORE_BYTES = 4096;
    localparam int MAX_GLYPH_ROWS    = 32;
    localparam int MAX_GLYPH_COLS    = 32;

    // glyph store depth is a power of two, address wrap is a truncation
    localparam int STORE_AW  = $clog2(GLYPH_STORE_BYTES);
    localparam int ROW_CNT_W = $clog2(MAX_GLYPH_ROWS);

    localparam int CUR_W   = 12;
    localparam int IDX_W   = 27;
    localparam int ADDR_W  = 5;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [1:0] OP_PRINT = 2'd0;
    localparam logic [1:0] OP_MOVE  = 2'd1;
    localparam logic [1:0] OP_STORE = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    localparam logic [2:0] REG_SCREEN_COLUMNS = 3'd0;
    localparam logic [2:0] REG_SCREEN_ROWS    = 3'd1;
    localparam logic [2:0] REG_ROW_PITCH      = 3'd2;
    localparam logic [2:0] REG_GLYPH_COLS     = 3'd3;
    localparam logic [2:0] REG_GLYPH_ROWS     = 3'd4;
    localparam logic [2:0] REG_GLYPH_COUNT    = 3'd5;
    localparam logic [2:0] REG_GLYPH_STRIDE   = 3'd6;
    localparam logic [2:0] REG_INK_COLOR      = 3'd7;

    localparam logic [12:0] RST_SCREEN_COLUMNS = 13'd1024;
    localparam logic [12:0] RST_SCREEN_ROWS    = 13'd768;
    localparam logic [14:0] RST_ROW_PITCH      = 15'd1024;
    localparam logic [5:0]  RST_GLYPH_COLS     = 6'd8;
    localparam logic [5:0]  RST_GLYPH_ROWS     = 6'd16;
    localparam logic [9:0]  RST_GLYPH_COUNT    = 10'd256;
    localparam logic [7:0]  RST_GLYPH_STRIDE   = 8'd16;
    localparam logic [31:0] RST_INK_COLOR      = 32'h00AAAAFF;

    typedef struct packed {
        logic [12:0] screen_columns;
        logic [12:0] screen_rows;
        logic [14:0] row_pitch;
        logic [5:0]  glyph_cols;
        logic [5:0]  glyph_rows;
        logic [9:0]  glyph_count;
        logic [7:0]  glyph_stride;
        logic [31:0] ink_color;
    } cfg_t;

    // one queued job: a character to draw or a glyph store write
    typedef struct packed {
        logic             is_store;
        logic [7:0]       glyph;
        logic [CUR_W-1:0] col;
        logic [CUR_W-1:0] row;
        logic [11:0]      addr;
        logic [7:0]       data;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [5:0] eff_cols(input logic [5:0] v);
        return (v > 6'(MAX_GLYPH_COLS)) ? 6'(MAX_GLYPH_COLS) : v;
    endfunction

    function automatic logic [5:0] eff_rows(input logic [5:0] v);
        return (v > 6'(MAX_GLYPH_ROWS)) ? 6'(MAX_GLYPH_ROWS) : v;
    endfunction

endpackage

// ===== rtl/bftr_if.sv =====
// valid/ready channel interfaces of the bitmap font text renderer
// no dependencies beyond the field widths of the block
interface bftr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [11:0] move_col;
    logic [11:0] move_row;
    logic [11:0] store_addr;
    logic [7:0]  store_byte;

    modport source (
        output valid, opcode, char_code, move_col, move_row, store_addr, store_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, char_code, move_col, move_row, store_addr, store_byte,
        output ready
    );
endinterface

interface bftr_span_if;
    logic        valid;
    logic        ready;
    logic [26:0] pixel_index;
    logic [31:0] lit_mask;
    logic [31:0] pixel_value;
    logic        last_row;

    modport source (
        output valid, pixel_index, lit_mask, pixel_value, last_row,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, lit_mask, pixel_value, last_row,
        output ready
    );
endinterface

// ===== rtl/bftr_cfg.sv =====
// apb register file of the bitmap font text renderer
// depends on bftr_pkg for register indexes, reset values and cfg_t
module bftr_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bftr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output bftr_pkg::cfg_t             cfg
);

    bftr_pkg::cfg_t cfg_reg;
    bftr_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bftr_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                bftr_pkg::REG_SCREEN_COLUMNS: cfg_next.screen_columns = pwdata[12:0];
                bftr_pkg::REG_SCREEN_ROWS:    cfg_next.screen_rows    = pwdata[12:0];
                bftr_pkg::REG_ROW_PITCH:      cfg_next.row_pitch      = pwdata[14:0];
                bftr_pkg::REG_GLYPH_COLS:     cfg_next.glyph_cols     = pwdata[5:0];
                bftr_pkg::REG_GLYPH_ROWS:     cfg_next.glyph_rows     = pwdata[5:0];
                bftr_pkg::REG_GLYPH_COUNT:    cfg_next.glyph_count    = pwdata[9:0];
                bftr_pkg::REG_GLYPH_STRIDE:   cfg_next.glyph_stride   = pwdata[7:0];
                bftr_pkg::REG_INK_COLOR:      cfg_next.ink_color      = pwdata;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            bftr_pkg::REG_SCREEN_COLUMNS: prdata = {19'd0, cfg_reg.screen_columns};
            bftr_pkg::REG_SCREEN_ROWS:    prdata = {19'd0, cfg_reg.screen_rows};
            bftr_pkg::REG_ROW_PITCH:      prdata = {17'd0, cfg_reg.row_pitch};
            bftr_pkg::REG_GLYPH_COLS:     prdata = {26'd0, cfg_reg.glyph_cols};
            bftr_pkg::REG_GLYPH_ROWS:     prdata = {26'd0, cfg_reg.glyph_rows};
            bftr_pkg::REG_GLYPH_COUNT:    prdata = {22'd0, cfg_reg.glyph_count};
            bftr_pkg::REG_GLYPH_STRIDE:   prdata = {24'd0, cfg_reg.glyph_stride};
            bftr_pkg::REG_INK_COLOR:      prdata = cfg_reg.ink_color;
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_columns <= bftr_pkg::RST_SCREEN_COLUMNS;
            cfg_reg.screen_rows    <= bftr_pkg::RST_SCREEN_ROWS;
            cfg_reg.row_pitch      <= bftr_pkg::RST_ROW_PITCH;
            cfg_reg.glyph_cols     <= bftr_pkg::RST_GLYPH_COLS;
            cfg_reg.glyph_rows     <= bftr_pkg::RST_GLYPH_ROWS;
            cfg_reg.glyph_count    <= bftr_pkg::RST_GLYPH_COUNT;
            cfg_reg.glyph_stride   <= bftr_pkg::RST_GLYPH_STRIDE;
            cfg_reg.ink_color      <= bftr_pkg::RST_INK_COLOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/bftr_front.sv =====
// front end: accepts command transactions, keeps the cursor, queues draw and store jobs
// depends on bftr_pkg and the bftr_cmd_if interface
module bftr_front (
    input  logic           clk,
    input  logic           rst_n,
    bftr_cmd_if.sink       cmd,
    input  bftr_pkg::cfg_t cfg,
    input  logic           q_full,
    output logic           push,
    output bftr_pkg::job_t job
);

    logic [bftr_pkg::CUR_W-1:0] col_reg, col_next;
    logic [bftr_pkg::CUR_W-1:0] row_reg, row_next;
    logic                       accept;
    logic [5:0]                 w;
    logic [5:0]                 h;
    logic [12:0]                nl_sum;
    logic [bftr_pkg::CUR_W-1:0] nl_row;
    logic [12:0]                adv_col;
    logic                       is_newline;

    assign cmd.ready  = !q_full;
    assign accept     = cmd.valid && cmd.ready;
    assign w          = bftr_pkg::eff_cols(cfg.glyph_cols);
    assign h          = bftr_pkg::eff_rows(cfg.glyph_rows);
    assign nl_sum     = {1'b0, row_reg} + {7'd0, h};
    assign nl_row     = (nl_sum >= cfg.screen_rows) ? '0 : nl_sum[bftr_pkg::CUR_W-1:0];
    assign adv_col    = {1'b0, col_reg} + {7'd0, w};
    assign is_newline = (cmd.char_code == bftr_pkg::NEWLINE_CODE);

    always_comb
    begin
        job.is_store = (cmd.opcode == bftr_pkg::OP_STORE);
        // codes past the glyph count draw the space glyph
        job.glyph    = ({2'b00, cmd.char_code} >= cfg.glyph_count) ? bftr_pkg::SPACE_CODE
                                                                   : cmd.char_code;
        job.col      = col_reg;
        job.row      = row_reg;
        job.addr     = cmd.store_addr;
        job.data     = cmd.store_byte;
    end

    always_comb
    begin
        push     = 1'b0;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            case (cmd.opcode)
                bftr_pkg::OP_PRINT:
                begin
                    if (is_newline)
                    begin
                        col_next = '0;
                        row_next = nl_row;
                    end
                    else
                    begin
                        push = 1'b1;
                        if (adv_col >= cfg.screen_columns)
                        begin
                            col_next = '0;
                            row_next = nl_row;
                        end
                        else
                        begin
                            col_next = adv_col[bftr_pkg::CUR_W-1:0];
                        end
                    end
                end
                bftr_pkg::OP_MOVE:
                begin
                    col_next = cmd.move_col;
                    row_next = cmd.move_row;
                end
                bftr_pkg::OP_STORE:
                begin
                    push = 1'b1;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/bftr_queue.sv =====
// short job queue between the front end and the glyph row engine
// depends on bftr_pkg for job_t, q_status_t and the queue depth
module bftr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bftr_pkg::job_t       job_in,
    input  logic                 pop,
    output bftr_pkg::job_t       job_out,
    output bftr_pkg::q_status_t  status
);

    bftr_pkg::job_t           entry_reg [bftr_pkg::Q_DEPTH];
    logic [bftr_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bftr_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bftr_pkg::Q_AW:0]   count_reg, count_next;
    logic                      do_push;
    logic                      do_pop;

    assign status.full  = (count_reg == (bftr_pkg::Q_AW + 1)'(bftr_pkg::Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign job_out      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/bftr_back.sv =====
// back end: glyph store memory and the glyph row engine that emits row transactions
// depends on bftr_pkg and the bftr_span_if interface
module bftr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bftr_pkg::cfg_t      cfg,
    input  bftr_pkg::job_t      head,
    input  bftr_pkg::q_status_t q_status,
    output logic                pop,
    bftr_span_if.source         span
);

    logic [7:0] store_mem [bftr_pkg::GLYPH_STORE_BYTES];
    logic [7:0] rd_byte_reg;

    // byte issue stage
    logic                           active_reg, active_next;
    logic [bftr_pkg::STORE_AW-1:0]  addr_reg, addr_next;
    logic [bftr_pkg::ROW_CNT_W-1:0] y_reg, y_next;
    logic [1:0]                     i_reg, i_next;
    logic [bftr_pkg::IDX_W-1:0]     idx_reg, idx_next;

    // byte in flight, data lands in rd_byte_reg
    logic                       p1_valid_reg;
    logic                       p1_first_reg;
    logic                       p1_last_byte_reg;
    logic                       p1_last_row_reg;
    logic [bftr_pkg::IDX_W-1:0] p1_idx_reg;

    logic [23:0] acc_reg;

    logic                       span_valid_reg, span_valid_next;
    logic [bftr_pkg::IDX_W-1:0] span_idx_reg;
    logic [31:0]                span_mask_reg;
    logic [31:0]                span_value_reg;
    logic                       span_last_reg;

    logic [5:0]                 w;
    logic [5:0]                 h;
    logic [6:0]                 w_round;
    logic [2:0]                 bpr;
    logic [1:0]                 last_i;
    logic                       stall;
    logic                       issue;
    logic                       load;
    logic                       start;
    logic                       mem_we;
    logic                       row_done;
    logic                       job_done;
    logic [15:0]                glyph_base;
    logic [bftr_pkg::IDX_W-1:0] row_prod;
    logic [bftr_pkg::IDX_W-1:0] start_idx;
    logic [31:0]                row_word;
    logic [31:0]                aligned;
    logic [32:0]                wfull;
    logic [31:0]                wmask;
    logic [31:0]                mask;
    logic                       land;

    assign w       = bftr_pkg::eff_cols(cfg.glyph_cols);
    assign h       = bftr_pkg::eff_rows(cfg.glyph_rows);
    assign w_round = {1'b0, w} + 7'd7;
    assign bpr     = w_round[5:3];
    // zero width still walks one dummy byte per row, its mask comes out empty
    assign last_i  = (bpr == 3'd0) ? 2'd0 : 2'(bpr - 3'd1);

    assign stall  = span_valid_reg && !span.ready;
    assign issue  = active_reg && !stall;
    assign load   = !active_reg && !q_status.empty;
    assign pop    = load;
    assign mem_we = load && head.is_store;
    assign start  = load && !head.is_store && (h != 6'd0);

    assign row_done = (i_reg == last_i);
    assign job_done = row_done && (6'(y_reg) == (h - 6'd1));

    assign glyph_base = {8'd0, head.glyph} * {8'd0, cfg.glyph_stride};
    assign row_prod   = bftr_pkg::IDX_W'(head.row) * bftr_pkg::IDX_W'(cfg.row_pitch);
    assign start_idx  = row_prod + bftr_pkg::IDX_W'(head.col);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[bftr_pkg::STORE_AW'(head.addr)] <= head.data;
        end
        if (issue)
        begin
            rd_byte_reg <= store_mem[addr_reg];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        addr_next   = addr_reg;
        y_next      = y_reg;
        i_next      = i_reg;
        idx_next    = idx_reg;
        if (start)
        begin
            active_next = 1'b1;
            addr_next   = bftr_pkg::STORE_AW'(glyph_base);
            y_next      = '0;
            i_next      = '0;
            idx_next    = start_idx;
        end
        else if (issue)
        begin
            // rows sit back to back in the store, so the address just counts up
            addr_next = addr_reg + 1'b1;
            if (row_done)
            begin
                i_next   = '0;
                y_next   = y_reg + 1'b1;
                idx_next = idx_reg + bftr_pkg::IDX_W'(cfg.row_pitch);
                if (job_done)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                i_next = i_reg + 1'b1;
            end
        end
    end

    assign land     = p1_valid_reg && !stall;
    assign row_word = p1_first_reg ? {24'd0, rd_byte_reg} : {acc_reg, rd_byte_reg};

    always_comb
    begin
        case (bpr)
            3'd1:    aligned = row_word << 24;
            3'd2:    aligned = row_word << 16;
            3'd3:    aligned = row_word << 8;
            default: aligned = row_word;
        endcase
        wfull = (33'd1 << w) - 33'd1;
        wmask = wfull[31:0];
        for (int x = 0; x < 32; x++)
        begin
            mask[x] = aligned[31 - x] & wmask[x];
        end
    end

    always_comb
    begin
        span_valid_next = span_valid_reg;
        if (span.ready)
        begin
            span_valid_next = 1'b0;
        end
        if (land && p1_last_byte_reg)
        begin
            span_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            p1_first_reg     <= (i_reg == 2'd0);
            p1_last_byte_reg <= row_done;
            p1_last_row_reg  <= job_done;
            p1_idx_reg       <= idx_reg;
        end
        if (land)
        begin
            acc_reg <= row_word[23:0];
        end
        if (land && p1_last_byte_reg)
        begin
            span_idx_reg   <= p1_idx_reg;
            span_mask_reg  <= mask;
            span_value_reg <= cfg.ink_color;
            span_last_reg  <= p1_last_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            addr_reg       <= '0;
            y_reg          <= '0;
            i_reg          <= '0;
            idx_reg        <= '0;
            p1_valid_reg   <= 1'b0;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            addr_reg       <= addr_next;
            y_reg          <= y_next;
            i_reg          <= i_next;
            idx_reg        <= idx_next;
            if (!stall)
            begin
                p1_valid_reg <= issue;
            end
            span_valid_reg <= span_valid_next;
        end
    end

    assign span.valid       = span_valid_reg;
    assign span.pixel_index = span_idx_reg;
    assign span.lit_mask    = span_mask_reg;
    assign span.pixel_value = span_value_reg;
    assign span.last_row    = span_last_reg;

endmodule

// ===== rtl/bitmap_font_text_renderer.sv =====
// Bitmap font text renderer. Command transactions on cmd print a character, move the cursor
// or write one byte of the 4096-byte glyph store; moves and newlines finish in the front end
// and give no output. A printed character gives one span transaction per glyph row (pixel
// index of the row start, lit column mask, ink colour, last_row on the final one). The glyph
// row engine reads one store byte per cycle, while the span output is not stalled, through a
// single memory port; it takes the next job only once every byte of a character is issued.
// A glyph store write is done by the engine as it takes the job from the queue. A four-entry
// job queue lets commands keep coming while characters are drawn. The glyph store has no
// reset and must be loaded before use. Registers sit on the apb port at 4*index; the user
// must write them only while the block is idle, the block itself does not enforce it.
// depends on bftr_pkg, bftr_if and the bftr_* submodules
module bitmap_font_text_renderer (
    input  logic                        clk,
    input  logic                        rst_n,
    bftr_cmd_if.sink                    cmd,
    bftr_span_if.source                 span,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bftr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    bftr_pkg::cfg_t      cfg;
    bftr_pkg::job_t      job_in;
    bftr_pkg::job_t      job_head;
    bftr_pkg::q_status_t q_status;
    logic                push;
    logic                pop;

    bftr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bftr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .q_full (q_status.full),
        .push   (push),
        .job    (job_in)
    );

    bftr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .job_out (job_head),
        .status  (q_status)
    );

    bftr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (job_head),
        .q_status (q_status),
        .pop      (pop),
        .span     (span)
    );

endmodule

// ===== rtl/bftr_checker.sv =====
// port-level checker of the bitmap font text renderer, bound to the top level
// depends on bftr_pkg and bitmap_font_text_renderer_macros.svh
`include "bitmap_font_text_renderer_macros.svh"

module bftr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        span_valid,
    input logic                        span_ready,
    input logic [26:0]                 span_pixel_index,
    input logic [31:0]                 span_lit_mask,
    input logic                        span_last_row,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic                        pready,
    input logic [bftr_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata
);

    logic wr_ink;
    logic wr_cols;
    logic rd_ink;
    logic rd_cols;

    assign wr_ink  = rst_n && psel && penable && pwrite && pready
                     && (paddr[bftr_pkg::ADDR_W-1:2] == bftr_pkg::REG_INK_COLOR);
    assign wr_cols = rst_n && psel && penable && pwrite && pready
                     && (paddr[bftr_pkg::ADDR_W-1:2] == bftr_pkg::REG_SCREEN_COLUMNS);
    assign rd_ink  = (paddr[bftr_pkg::ADDR_W-1:2] == bftr_pkg::REG_INK_COLOR);
    assign rd_cols = (paddr[bftr_pkg::ADDR_W-1:2] == bftr_pkg::REG_SCREEN_COLUMNS);

    // a stalled span transaction keeps its pixel index, lit mask and last_row
    `BFTR_ASSERT_NEXT(a_span_hold, clk, rst_n, span_valid && !span_ready, span_valid && $stable(span_pixel_index) && $stable(span_lit_mask) && $stable(span_last_row))

    // ink colour and screen columns readback reflects the last completed write
    `BFTR_ASSERT_NEXT(a_ink_readback, clk, rst_n, wr_ink, !rd_ink || (prdata == $past(pwdata)))
    `BFTR_ASSERT_NEXT(a_cols_readback, clk, rst_n, wr_cols, !rd_cols || (prdata == {19'd0, $past(pwdata[12:0])}))

endmodule

bind bitmap_font_text_renderer bftr_checker u_bftr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .span_valid       (span.valid),
    .span_ready       (span.ready),
    .span_pixel_index (span.pixel_index),
    .span_lit_mask    (span.lit_mask),
    .span_last_row    (span.last_row),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the bitmap font text renderer
// depends on bftr_pkg, the bftr_cmd_if / bftr_span_if interfaces and the renderer top level
// commands go in through a queued driver, spans are checked against a glyph row predictor
module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [11:0] move_col;
        logic [11:0] move_row;
        logic [11:0] store_addr;
        logic [7:0]  store_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [26:0] pixel_index;
        logic [31:0] lit_mask;
        logic [31:0] pixel_value;
        logic        last_row;
    } span_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [bftr_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    cmd_item_t           cmd_drive = '0;
    logic                cmd_valid_q = 1'b0;
    logic                span_ready_q = 1'b0;

    bftr_cmd_if  cmd_bus ();
    bftr_span_if span_bus ();

    assign cmd_bus.valid      = cmd_valid_q;
    assign cmd_bus.opcode     = cmd_drive.opcode;
    assign cmd_bus.char_code  = cmd_drive.char_code;
    assign cmd_bus.move_col   = cmd_drive.move_col;
    assign cmd_bus.move_row   = cmd_drive.move_row;
    assign cmd_bus.store_addr = cmd_drive.store_addr;
    assign cmd_bus.store_byte = cmd_drive.store_byte;
    assign span_bus.ready     = span_ready_q;

    bitmap_font_text_renderer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus),
        .span    (span_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state: registers, cursor and glyph store
    bftr_pkg::cfg_t cfg;
    logic [11:0]    cur_col = '0;
    logic [11:0]    cur_row = '0;
    logic [7:0]     glyph_mem [bftr_pkg::GLYPH_STORE_BYTES];

    // stimulus side bookkeeping
    cmd_item_t   cmd_backlog [$];
    bit          glyph_loaded [bftr_pkg::GLYPH_STORE_BYTES];
    span_t       spans_due [$];
    int          cmds_taken = 0;
    int          spans_taken = 0;
    int          errors = 0;
    int          idle_pct = 0;
    int          hold_at = -1;

    function automatic int unsigned glyph_width();
        return (cfg.glyph_cols > bftr_pkg::MAX_GLYPH_COLS) ? bftr_pkg::MAX_GLYPH_COLS
                                                           : cfg.glyph_cols;
    endfunction

    function automatic int unsigned glyph_height();
        return (cfg.glyph_rows > bftr_pkg::MAX_GLYPH_ROWS) ? bftr_pkg::MAX_GLYPH_ROWS
                                                           : cfg.glyph_rows;
    endfunction

    function automatic int unsigned glyph_index(logic [7:0] code);
        return (code >= cfg.glyph_count) ? bftr_pkg::SPACE_CODE : code;
    endfunction

    function automatic void line_feed();
        int unsigned r;
        r = cur_row + glyph_height();
        cur_col = '0;
        if (r >= cfg.screen_rows)
            r = 0;
        cur_row = r[11:0];
    endfunction

    // expected spans of one accepted command, cursor and store updated in order
    function automatic void render_command(cmd_item_t c);
        int unsigned w, h, bpr, base, x, y, i, adv;
        longint unsigned idx;
        logic [63:0] bits;
        span_t s;
        case (c.opcode)
            bftr_pkg::OP_MOVE:
            begin
                cur_col = c.move_col;
                cur_row = c.move_row;
            end
            bftr_pkg::OP_STORE:
                glyph_mem[c.store_addr] = c.store_byte;
            bftr_pkg::OP_PRINT:
                if (c.char_code == bftr_pkg::NEWLINE_CODE)
                    line_feed();
                else
                begin
                    w = glyph_width();
                    h = glyph_height();
                    bpr = (w + 7) / 8;
                    base = glyph_index(c.char_code) * cfg.glyph_stride;
                    for (y = 0; y < h; y++)
                    begin
                        bits = '0;
                        for (i = 0; i < bpr; i++)
                            bits = (bits << 8)
                                   | glyph_mem[(base + y * bpr + i) % bftr_pkg::GLYPH_STORE_BYTES];
                        s.lit_mask = '0;
                        // row bytes are big-endian, leftmost column is the top bit
                        for (x = 0; x < w; x++)
                            s.lit_mask[x] = bits[bpr * 8 - 1 - x];
                        idx = (longint'(cur_row) + y) * cfg.row_pitch + cur_col;
                        s.pixel_index = idx[26:0];
                        s.pixel_value = cfg.ink_color;
                        s.last_row = (y + 1 == h);
                        spans_due.push_back(s);
                    end
                    adv = cur_col + w;
                    if (adv >= cfg.screen_columns)
                        line_feed();
                    else
                        cur_col = adv[11:0];
                end
            default:
                ;
        endcase
    endfunction

    function automatic cmd_item_t blank_cmd(logic [1:0] op);
        cmd_item_t c;
        c.opcode     = op;
        c.char_code  = 8'($urandom);
        c.move_col   = 12'($urandom);
        c.move_row   = 12'($urandom);
        c.store_addr = 12'($urandom);
        c.store_byte = 8'($urandom);
        return c;
    endfunction

    function automatic void push_store(logic [11:0] addr, logic [7:0] value);
        cmd_item_t c;
        c = blank_cmd(bftr_pkg::OP_STORE);
        c.store_addr = addr;
        c.store_byte = value;
        glyph_loaded[addr] = 1'b1;
        cmd_backlog.push_back(c);
    endfunction

    function automatic void push_move(logic [11:0] col, logic [11:0] row);
        cmd_item_t c;
        c = blank_cmd(bftr_pkg::OP_MOVE);
        c.move_col = col;
        c.move_row = row;
        cmd_backlog.push_back(c);
    endfunction

    // loads any glyph bytes the character will read that were never written
    function automatic void push_char(logic [7:0] code);
        int unsigned bpr, base, a, k;
        cmd_item_t c;
        c = blank_cmd(bftr_pkg::OP_PRINT);
        c.char_code = code;
        if (code != bftr_pkg::NEWLINE_CODE)
        begin
            bpr = (glyph_width() + 7) / 8;
            base = glyph_index(code) * cfg.glyph_stride;
            for (k = 0; k < glyph_height() * bpr; k++)
            begin
                a = (base + k) % bftr_pkg::GLYPH_STORE_BYTES;
                if (!glyph_loaded[a])
                    push_store(a[11:0], 8'($urandom));
            end
        end
        cmd_backlog.push_back(c);
    endfunction

    // characters come half the time from a small code pool so glyph loads stay few
    function automatic void random_phase(int count);
        int done, pick;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            if (pick < 66)
                push_char(8'($urandom_range(1) ? $urandom_range(34, 30) : $urandom));
            else if (pick < 74)
                push_char(bftr_pkg::NEWLINE_CODE);
            else if (pick < 84)
            begin
                if ($urandom_range(1))
                    push_move(12'($urandom), 12'($urandom));
                else
                    push_move(12'($urandom_range(cfg.screen_columns)),
                              12'($urandom_range(cfg.screen_rows)));
            end
            else if (pick < 94)
                push_store(12'($urandom), 8'($urandom));
            else
                cmd_backlog.push_back(blank_cmd(OP_UNUSED));
            if (pick < 94)
                done++;
        end
    endfunction

    function automatic bftr_pkg::cfg_t random_setup(bit roomy);
        bftr_pkg::cfg_t s;
        s.screen_columns = 13'($urandom_range(1) ? $urandom_range(4096, 1) : $urandom_range(256, 8));
        s.screen_rows    = 13'($urandom_range(1) ? $urandom_range(4096, 1) : $urandom_range(256, 8));
        s.row_pitch      = 15'($urandom_range(16384, 1));
        s.glyph_cols     = 6'(roomy ? $urandom_range(32, 17) : $urandom_range(12, 1));
        s.glyph_rows     = 6'($urandom_range(4, 1));
        s.glyph_count    = 10'($urandom_range(1) ? $urandom_range(40, 31) : $urandom_range(30, 1));
        s.glyph_stride   = 8'($urandom_range(4, 1));
        s.ink_color      = $urandom;
        return s;
    endfunction

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (index)
            bftr_pkg::REG_SCREEN_COLUMNS: cfg.screen_columns = value[12:0];
            bftr_pkg::REG_SCREEN_ROWS:    cfg.screen_rows    = value[12:0];
            bftr_pkg::REG_ROW_PITCH:      cfg.row_pitch      = value[14:0];
            bftr_pkg::REG_GLYPH_COLS:     cfg.glyph_cols     = value[5:0];
            bftr_pkg::REG_GLYPH_ROWS:     cfg.glyph_rows     = value[5:0];
            bftr_pkg::REG_GLYPH_COUNT:    cfg.glyph_count    = value[9:0];
            bftr_pkg::REG_GLYPH_STRIDE:   cfg.glyph_stride   = value[7:0];
            default:                      cfg.ink_color      = value;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_setup(input bftr_pkg::cfg_t s);
        write_reg(bftr_pkg::REG_SCREEN_COLUMNS, 32'(s.screen_columns));
        write_reg(bftr_pkg::REG_SCREEN_ROWS,    32'(s.screen_rows));
        write_reg(bftr_pkg::REG_ROW_PITCH,      32'(s.row_pitch));
        write_reg(bftr_pkg::REG_GLYPH_COLS,     32'(s.glyph_cols));
        write_reg(bftr_pkg::REG_GLYPH_ROWS,     32'(s.glyph_rows));
        write_reg(bftr_pkg::REG_GLYPH_COUNT,    32'(s.glyph_count));
        write_reg(bftr_pkg::REG_GLYPH_STRIDE,   32'(s.glyph_stride));
        write_reg(bftr_pkg::REG_INK_COLOR,      s.ink_color);
    endtask

    // sender holds until every command is taken and every span is back
    task automatic settle();
        while (cmds_taken != cmd_backlog.size() || spans_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic void flag_field(string name, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    endfunction

    // command driver
    int issued = 0;
    int cmd_gap = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_valid_q <= 1'b0;
        else if (!(cmd_valid_q && cmds_taken == issued))
        begin
            // valid high here means the offered transaction was taken
            if (cmd_valid_q)
                issued = issued + 1;
            if (cmd_gap > 0)
            begin
                cmd_gap--;
                cmd_valid_q <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                cmd_gap = $urandom_range(15);
                cmd_valid_q <= 1'b0;
            end
            else if (issued < cmd_backlog.size())
            begin
                cmd_drive   <= cmd_backlog[issued];
                cmd_valid_q <= 1'b1;
            end
            else
                cmd_valid_q <= 1'b0;
        end
    end

    // span receiver
    int ready_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            span_ready_q <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            span_ready_q <= 1'b0;
        end
        else if (!hold_done && hold_at >= 0 && spans_taken >= hold_at)
        begin
            // long back-pressure so the job queue fills and cmd stalls
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            span_ready_q <= 1'b0;
        end
        else if (ready_gap > 0)
        begin
            ready_gap--;
            span_ready_q <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            ready_gap = $urandom_range(15);
            span_ready_q <= 1'b0;
        end
        else
            span_ready_q <= 1'b1;
    end

    // monitor: check spans first, then predict from the accepted command
    always @(posedge clk)
    begin
        span_t got, want;
        if (rst_n)
        begin
            if (span_bus.valid && span_bus.ready)
            begin
                spans_taken++;
                got = {span_bus.pixel_index, span_bus.lit_mask, span_bus.pixel_value,
                       span_bus.last_row};
                if (spans_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected span, expected none actual %h", $time, got);
                end
                else
                begin
                    want = spans_due.pop_front();
                    if (got.pixel_index !== want.pixel_index)
                        flag_field("pixel_index", 32'(want.pixel_index), 32'(got.pixel_index));
                    if (got.lit_mask !== want.lit_mask)
                        flag_field("lit_mask", want.lit_mask, got.lit_mask);
                    if (got.pixel_value !== want.pixel_value)
                        flag_field("pixel_value", want.pixel_value, got.pixel_value);
                    if (got.last_row !== want.last_row)
                        flag_field("last_row", 32'(want.last_row), 32'(got.last_row));
                end
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                cmds_taken++;
                render_command({cmd_bus.opcode, cmd_bus.char_code, cmd_bus.move_col,
                                cmd_bus.move_row, cmd_bus.store_addr, cmd_bus.store_byte});
            end
        end
    end

    // watchdog on cycles without any transaction
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (span_bus.valid && span_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("bitmap_font_text_renderer regression: fail");
            $finish;
        end
    end

    initial
    begin
        cfg = {bftr_pkg::RST_SCREEN_COLUMNS, bftr_pkg::RST_SCREEN_ROWS, bftr_pkg::RST_ROW_PITCH,
               bftr_pkg::RST_GLYPH_COLS, bftr_pkg::RST_GLYPH_ROWS, bftr_pkg::RST_GLYPH_COUNT,
               bftr_pkg::RST_GLYPH_STRIDE, bftr_pkg::RST_INK_COLOR};
        idle_pct = 25;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // reset font geometry: store extremes, edge wraps, unused opcode
        push_store(12'd0, 8'hFF);
        push_store(12'd4095, 8'h00);
        push_char(8'd255);
        push_char(bftr_pkg::NEWLINE_CODE);
        push_move(12'd1016, 12'd0);
        push_char(8'd255);
        push_move(12'd4095, 12'd4095);
        push_char(8'd255);
        push_move(12'd0, 12'd752);
        push_char(bftr_pkg::NEWLINE_CODE);
        cmd_backlog.push_back(blank_cmd(OP_UNUSED));
        push_store(12'd4085, 8'hA5);
        push_char(8'd255);
        settle();

        // widest glyphs, wrapping store addresses, codes past the glyph count
        load_setup({13'd4096, 13'd4096, 15'd16384, 6'd32, 6'd2, 10'd40, 8'd128, 32'hFFFFFFFF});
        push_char(8'd255);
        push_char(8'd40);
        push_move(12'd4064, 12'd4064);
        push_char(8'd0);
        push_char(bftr_pkg::NEWLINE_CODE);
        settle();

        // zero width on a zero-size screen
        load_setup({13'd0, 13'd0, 15'd1, 6'd0, 6'd5, 10'd1, 8'd1, 32'h0});
        push_char(8'd0);
        push_char(8'd200);
        push_move(12'd7, 12'd9);
        push_char(8'd5);
        push_char(bftr_pkg::NEWLINE_CODE);
        settle();

        // zero height with an oversize width
        load_setup({13'd100, 13'd50, 15'd3, 6'd63, 6'd0, 10'd512, 8'd3, 32'h12345678});
        push_char(8'd7);
        push_char(8'd8);
        settle();

        // oversize height clamps, also as the newline step
        load_setup({13'd100, 13'd50, 15'd3, 6'd0, 6'd63, 10'd512, 8'd3, 32'h87654321});
        push_char(8'd9);
        push_char(bftr_pkg::NEWLINE_CODE);
        push_char(8'd100);
        settle();

        load_setup(random_setup(1'b0));
        idle_pct = 20;
        hold_at = spans_taken + 1;
        random_phase(12);
        settle();

        load_setup(random_setup(1'b1));
        idle_pct = 40;
        random_phase(8);
        settle();

        load_setup(random_setup(1'b0));
        idle_pct = 0;
        random_phase(10);
        settle();

        if (errors == 0 && spans_due.size() == 0)
            $display("bitmap_font_text_renderer regression: pass");
        else
            $display("bitmap_font_text_renderer regression: fail");
        $finish;
    end

endmodule
